[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared payload types, command codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int PROD_WIDTH    = 64;
   localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } command_type;

   typedef enum logic {
      STATUS_OK       = 1'b0,
      STATUS_DIV_ZERO = 1'b1
   } status_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [63:0] res_num;
      logic [62:0]        res_den;
      logic               status;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,     // capture operands and check for invalid input
      OP_PROD,     // form the numerator terms, then the denominator
      OP_COMBINE,  // add/subtract/select, fix signs, take magnitude
      OP_DIV_INIT, // start a restoring division of x by y, or of num/den by x
      OP_DIV_STEP, // one quotient bit
      OP_GCD_NEXT, // x <= y, y <= remainder
      OP_REDUCE    // divide numerator or denominator by the gcd
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      div_den; // during reduction: divide denominator instead
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;   // special case: result is 0/1
      logic zero_num;  // combined numerator is zero
      logic y_zero;    // gcd loop finished
      logic div_done;  // division unit finished
   } dp_status_type;

endpackage

[rtl/core/rau_datapath.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand registers, signed 33x33 multipliers used over two product phases,
// and a bit-serial divider shared by the gcd loop and the final reduction.
// ----------------------------------------------------------------------------
module rau_datapath (
   input  logic               clock,
   input  logic               reset,
   input  rau_pkg::req_type   req_payload,
   input  rau_pkg::dp_cmd_type cmd,
   output rau_pkg::dp_status_type status,
   output rau_pkg::rsp_type   rsp_payload
);
   import rau_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [1:0]                  command_ff;
   logic signed [W-1:0]         an_ff, bn_ff;
   logic [W-2:0]                ad_ff, bd_ff;
   logic                        invalid_ff;
   logic signed [PROD_WIDTH-1:0] p0_ff, p1_ff, d_ff;
   logic [PROD_WIDTH-1:0]       mag_ff, den_ff, x_ff, y_ff;
   logic                        neg_ff;
   logic [PROD_WIDTH-1:0]       quo_ff, rem_ff, dvd_ff, dvs_ff;
   logic [DIV_CNT_WIDTH-1:0]    cnt_ff;
   logic [1:0]                  phase_ff;

   logic signed [W-1:0]          in_an, in_bn;
   logic [W-2:0]                 in_ad, in_bd;
   logic signed [PROD_WIDTH-1:0] n_sum, n_fix, d_fix;
   logic [PROD_WIDTH:0]          rem_sh, rem_sub;
   logic signed [W:0]            mul_a0, mul_b0, mul_a1, mul_b1;
   logic signed [PROD_WIDTH-1:0] prod0, prod1, prod_d;

   assign in_an = W'(req_payload.a_num);
   assign in_bn = W'(req_payload.b_num);
   assign in_ad = (W-1)'(req_payload.a_den);
   assign in_bd = (W-1)'(req_payload.b_den);

   // Numerator products use the den of the other operand.
   always_comb begin
      mul_a0 = (W+1)'(an_ff);
      mul_b0 = $signed({2'b00, bd_ff});
      mul_a1 = $signed({2'b00, ad_ff});
      mul_b1 = (W+1)'(bn_ff);
      case (phase_ff)
         2'd1: begin
            if (command_ff == CMD_DIV) begin
               mul_a0 = mul_a1;     // d = ad*bn for divide
            end else begin
               mul_b0 = $signed({2'b00, bd_ff}); // d = ad*bd
               mul_a0 = mul_a1;
            end
         end
         default: ;
      endcase
   end
   assign prod0  = PROD_WIDTH'(mul_a0 * mul_b0);
   assign prod1  = PROD_WIDTH'(mul_a1 * mul_b1);
   assign prod_d = (command_ff == CMD_DIV) ? PROD_WIDTH'(mul_a1 * mul_b1)
                                           : PROD_WIDTH'(mul_a0 * mul_b0);

   always_comb begin
      case (command_ff)
         CMD_ADD: n_sum = p0_ff + p1_ff;
         CMD_SUB: n_sum = p0_ff - p1_ff;
         CMD_MUL: n_sum = p1_ff;
         default: n_sum = p0_ff;
      endcase
      n_fix = (d_ff < 0) ? -n_sum : n_sum;
      d_fix = (d_ff < 0) ? -d_ff : d_ff;
   end

   assign rem_sh  = {rem_ff, dvd_ff[PROD_WIDTH-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               command_ff <= req_payload.command;
               an_ff      <= in_an;
               bn_ff      <= in_bn;
               ad_ff      <= in_ad;
               bd_ff      <= in_bd;
               invalid_ff <= (in_ad == '0) || (in_bd == '0) ||
                             (req_payload.command == CMD_DIV && in_bn == '0);
               phase_ff   <= 2'd0;
            end
            OP_PROD: begin
               // Phase 0: numerator terms; phase 1: denominator.
               if (phase_ff == 2'd0) begin
                  p0_ff    <= prod0;
                  p1_ff    <= (command_ff == CMD_MUL) ?
                              PROD_WIDTH'(mul_a0 * (W+1)'(bn_ff)) : prod1;
                  phase_ff <= 2'd1;
               end else begin
                  d_ff     <= prod_d;
                  phase_ff <= 2'd0;
               end
            end
            OP_COMBINE: begin
               neg_ff <= n_fix < 0;
               mag_ff <= (n_fix < 0) ? PROD_WIDTH'(-n_fix) : PROD_WIDTH'(n_fix);
               den_ff <= PROD_WIDTH'(d_fix);
               x_ff   <= (n_fix < 0) ? PROD_WIDTH'(-n_fix) : PROD_WIDTH'(n_fix);
               y_ff   <= PROD_WIDTH'(d_fix);
               p0_ff  <= n_fix;
            end
            OP_DIV_INIT: begin
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= '0;
               if (phase_ff == 2'd2) begin
                  dvd_ff <= cmd.div_den ? den_ff : mag_ff;
                  dvs_ff <= x_ff;
               end else begin
                  dvd_ff <= x_ff;
                  dvs_ff <= y_ff;
               end
            end
            OP_DIV_STEP: begin
               dvd_ff <= dvd_ff << 1;
               if (!rem_sub[PROD_WIDTH]) begin
                  rem_ff <= rem_sub[PROD_WIDTH-1:0];
                  quo_ff <= {quo_ff[PROD_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[PROD_WIDTH-1:0];
                  quo_ff <= {quo_ff[PROD_WIDTH-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            OP_GCD_NEXT: begin
               x_ff <= y_ff;
               y_ff <= rem_ff;
               if (rem_ff == '0) begin
                  phase_ff <= 2'd2;
               end
            end
            OP_REDUCE: begin
               if (cmd.div_den) begin
                  den_ff <= quo_ff;
               end else begin
                  mag_ff <= quo_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign status.invalid  = invalid_ff;
   assign status.zero_num = (p0_ff == '0);
   assign status.y_zero   = (y_ff == '0);
   assign status.div_done = (cnt_ff == DIV_CNT_WIDTH'(PROD_WIDTH));

   always_comb begin
      if (invalid_ff) begin
         rsp_payload.res_num = '0;
         rsp_payload.res_den = 63'd1;
         rsp_payload.status  = STATUS_DIV_ZERO;
      end else if (p0_ff == '0) begin
         rsp_payload.res_num = '0;
         rsp_payload.res_den = 63'd1;
         rsp_payload.status  = STATUS_OK;
      end else begin
         rsp_payload.res_num = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
         rsp_payload.res_den = den_ff[62:0];
         rsp_payload.status  = STATUS_OK;
      end
   end

endmodule

[rtl/core/rau_control.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences load, products, combine, the Euclidean gcd loop and reduction.
// ----------------------------------------------------------------------------
module rau_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD0, ST_PROD1, ST_COMBINE, ST_CHECK,
      ST_GCD_INIT, ST_GCD_STEP, ST_GCD_NEXT, ST_GCD_WAIT,
      ST_RN_INIT, ST_RN_STEP, ST_RN_DONE,
      ST_RD_INIT, ST_RD_STEP, ST_RD_DONE, ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.div_den = 1'b0;
      case (state_ff)
         ST_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
         ST_PROD0,
         ST_PROD1:    cmd.op = OP_PROD;
         ST_COMBINE:  cmd.op = OP_COMBINE;
         ST_GCD_INIT,
         ST_RN_INIT:  cmd.op = OP_DIV_INIT;
         ST_GCD_STEP,
         ST_RN_STEP:  cmd.op = status.div_done ? OP_NONE : OP_DIV_STEP;
         ST_GCD_NEXT: cmd.op = OP_GCD_NEXT;
         ST_RN_DONE:  cmd.op = OP_REDUCE;
         ST_RD_INIT: begin
            cmd.op      = OP_DIV_INIT;
            cmd.div_den = 1'b1;
         end
         ST_RD_STEP:  begin
            cmd.op      = status.div_done ? OP_NONE : OP_DIV_STEP;
            cmd.div_den = 1'b1;
         end
         ST_RD_DONE: begin
            cmd.op      = OP_REDUCE;
            cmd.div_den = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DONE);
         case (state_ff)
            ST_IDLE:     if (start) state_ff <= ST_PROD0;
            ST_PROD0:    state_ff <= ST_PROD1;
            ST_PROD1:    state_ff <= ST_COMBINE;
            ST_COMBINE:  state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (status.invalid || status.zero_num) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_GCD_INIT;
               end
            end
            ST_GCD_INIT: state_ff <= ST_GCD_STEP;
            ST_GCD_STEP: if (status.div_done) state_ff <= ST_GCD_NEXT;
            ST_GCD_NEXT: state_ff <= ST_GCD_WAIT;
            // The gcd loop ends when the new y (the old remainder) is zero.
            ST_GCD_WAIT: state_ff <= status.y_zero ? ST_RN_INIT : ST_GCD_INIT;
            ST_RN_INIT:  state_ff <= ST_RN_STEP;
            ST_RN_STEP:  if (status.div_done) state_ff <= ST_RN_DONE;
            ST_RN_DONE:  state_ff <= ST_RD_INIT;
            ST_RD_INIT:  state_ff <= ST_RD_STEP;
            ST_RD_STEP:  if (status.div_done) state_ff <= ST_RD_DONE;
            ST_RD_DONE:  state_ff <= ST_DONE;
            ST_DONE:     state_ff <= ST_IDLE;
            default:     state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_valid_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while strobing response");
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not start");
`endif

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the
// result by the gcd of numerator and denominator magnitudes.
//
//  channel   ports                              handshake
//  request   req_payload                        start && !busy
//  response  rsp_payload                        rsp_valid (one cycle)
//
// One transaction at a time. After the load, the products and the combine step,
// a result that needs reducing runs Euclid steps and then two reduction
// divisions on the shared one-bit-per-cycle divider. Invalid and zero results
// skip the gcd loop and the reduction.
// Reset is synchronous and returns the controller to idle.
// The receiver cannot stall; each response is strobed for one cycle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_payload,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_payload
);
   import rau_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rau_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[sim/rational_arithmetic_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction pairs with all four commands to the unit. A directed table
// covers the extremes, zero results and the error cases. Random transactions
// follow under three sender pacing phases. Untyped ones are checked against
// a predictor that reduces the exact result by the gcd of its magnitudes.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   localparam longint CYCLE_LIMIT  = 64'd40_000_000;
   localparam int     RANDOM_COUNT = 2000;
   localparam int     DRAIN_CYCLES = 200;

   typedef struct {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } vector_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   rsp_type    pending_fractions[$];
   int         error_count;
   longint     cycle_count;
   int         sender_idle_pct;
   vector_type vectors[$];

   rational_arithmetic_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint unsigned gcd_of(input longint unsigned x,
                                               input longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic rsp_type reduced_fraction(input req_type r);
      rsp_type         f;
      longint          an, ad, bn, bd, n, d;
      longint unsigned mag, g;
      logic            neg;
      an = r.a_num;
      bn = r.b_num;
      ad = longint'({33'd0, r.a_den});
      bd = longint'({33'd0, r.b_den});
      f.res_num = 64'sd0;
      f.res_den = 63'd1;
      f.status  = STATUS_OK;
      if (ad == 0 || bd == 0 || (command_type'(r.command) == CMD_DIV && bn == 0)) begin
         f.status = STATUS_DIV_ZERO;
         return f;
      end
      case (command_type'(r.command))
         CMD_ADD: begin
            n = an * bd + ad * bn;
            d = ad * bd;
         end
         CMD_SUB: begin
            n = an * bd - ad * bn;
            d = ad * bd;
         end
         CMD_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
            if (d < 0) begin
               n = -n;
               d = -d;
            end
         end
      endcase
      if (n == 0) return f;
      neg = n < 0;
      mag = neg ? longint'(-n) : n;
      g = gcd_of(mag, d);
      mag = mag / g;
      f.res_num = neg ? -longint'(mag) : longint'(mag);
      f.res_den = 63'(longint'(d) / g);
      return f;
   endfunction

   function automatic req_type make_req(input command_type c, input int an,
                                        input int unsigned ad, input int bn,
                                        input int unsigned bd);
      req_type r;
      r.command = c;
      r.a_num   = an;
      r.a_den   = ad[30:0];
      r.b_num   = bn;
      r.b_den   = bd[30:0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(input longint n, input longint unsigned d,
                                        input status_type s);
      rsp_type f;
      f.res_num = n;
      f.res_den = d[62:0];
      f.status  = s;
      return f;
   endfunction

   function automatic int rand_num();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 0;
         3, 4: return $urandom_range(40) - 20;
         5: return int'($urandom_range(5000)) - 2500;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned rand_den();
      case ($urandom_range(19))
         0: return 0;
         1: return 32'h7fff_ffff;
         2, 3, 4: return $urandom_range(1, 24);
         5, 6: return $urandom_range(1, 5000);
         default: return $urandom_range(1, 32'h7fff_ffff);
      endcase
   endfunction

   // Drives one transaction, holds start until accepted and records the
   // expected response. Returns at the falling edge after acceptance.
   task automatic send_fraction_pair(input req_type r, input logic typed,
                                     input rsp_type typed_rsp);
      start       <= 1'b1;
      req_payload <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_fractions.push_back(typed ? typed_rsp : reduced_fraction(r));
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch($sformatf("status %0b want %0b",
                                         rsp_payload.status, want.status));
            if (rsp_payload.res_num !== want.res_num)
               report_mismatch($sformatf("res_num %0d want %0d",
                                         rsp_payload.res_num, want.res_num));
            if (rsp_payload.res_den !== want.res_den)
               report_mismatch($sformatf("res_den %0d want %0d",
                                         rsp_payload.res_den, want.res_den));
         end
      end
   end

   initial begin
      rsp_type none;
      req_type r;
      int      drain;
      none            = make_rsp(0, 1, STATUS_OK);
      error_count     = 0;
      cycle_count     = 0;
      sender_idle_pct = 0;
      start           = 1'b0;
      req_payload     = '0;
      reset           = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Typed rows: zero results, error cases and extreme magnitudes.
      vectors.push_back('{make_req(CMD_ADD, 0, 1, 0, 1), 1'b1, none});
      vectors.push_back('{make_req(CMD_ADD, 1, 1, 1, 1), 1'b1,
                          make_rsp(2, 1, STATUS_OK)});
      vectors.push_back('{make_req(CMD_SUB, 5, 7, 5, 7), 1'b1, none});
      vectors.push_back('{make_req(CMD_MUL, 0, 3, -9, 4), 1'b1, none});
      vectors.push_back('{make_req(CMD_DIV, 3, 4, 0, 9), 1'b1,
                          make_rsp(0, 1, STATUS_DIV_ZERO)});
      vectors.push_back('{make_req(CMD_ADD, 3, 0, 1, 2), 1'b1,
                          make_rsp(0, 1, STATUS_DIV_ZERO)});
      vectors.push_back('{make_req(CMD_MUL, 3, 2, 1, 0), 1'b1,
                          make_rsp(0, 1, STATUS_DIV_ZERO)});
      vectors.push_back('{make_req(CMD_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1),
                          1'b1, make_rsp(64'sh4000_0000_0000_0000, 1, STATUS_OK)});
      vectors.push_back('{make_req(CMD_DIV, 32'sh7fff_ffff, 1, 32'sh8000_0000, 1),
                          1'b1, make_rsp(-64'sd2147483647, 64'd2147483648, STATUS_OK)});
      vectors.push_back('{make_req(CMD_DIV, 0, 5, 7, 3), 1'b1, none});
      // Predicted rows.
      vectors.push_back('{make_req(CMD_ADD, 32'sh7fff_ffff, 32'h7fff_ffff,
                                   32'sh7fff_ffff, 1), 1'b0, none});
      vectors.push_back('{make_req(CMD_SUB, 32'sh8000_0000, 32'h7fff_ffff,
                                   32'sh7fff_ffff, 32'h7fff_fffe), 1'b0, none});
      vectors.push_back('{make_req(CMD_ADD, 32'sh8000_0000, 32'h7fff_ffff,
                                   32'sh8000_0000, 32'h7fff_fffe), 1'b0, none});
      vectors.push_back('{make_req(CMD_MUL, -6, 4, 10, 15), 1'b0, none});
      vectors.push_back('{make_req(CMD_DIV, 6, 4, -10, 15), 1'b0, none});
      vectors.push_back('{make_req(CMD_DIV, -1, 32'h7fff_ffff, -1, 1), 1'b0, none});
      vectors.push_back('{make_req(CMD_SUB, 1, 3, -1, 6), 1'b0, none});
      vectors.push_back('{make_req(CMD_ADD, 32'sh5555_5555, 32'h2aaa_aaaa,
                                   32'shaaaa_aaaa, 32'h5555_5555), 1'b0, none});
      vectors.push_back('{make_req(CMD_MUL, 32'sh7fff_ffff, 32'h7fff_ffff,
                                   32'sh7fff_ffff, 32'h7fff_ffff), 1'b0, none});
      foreach (vectors[i]) send_fraction_pair(vectors[i].req, vectors[i].typed,
                                              vectors[i].rsp);

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 3) sender_idle_pct = 76;
         if (i == 2 * RANDOM_COUNT / 3) sender_idle_pct = 0;
         if (i == 0) sender_idle_pct = 33;
         if (i == RANDOM_COUNT / 2) begin
            // Let the unit run dry before carrying on.
            start <= 1'b0;
            @(negedge clock);
            while (pending_fractions.size() != 0) @(negedge clock);
         end
         r.command = command_type'($urandom_range(3));
         r.a_num   = rand_num();
         r.b_num   = rand_num();
         r.a_den   = 31'(rand_den());
         r.b_den   = 31'(rand_den());
         send_fraction_pair(r, 1'b0, none);
         sender_gap();
      end
      start <= 1'b0;

      while (pending_fractions.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      if (error_count == 0 && pending_fractions.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/rau_pkg.sv
rtl/core/rau_datapath.sv
rtl/core/rau_control.sv
rtl/core/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
